/* rtl/max_independent_set_min_cost_macros.svh */
// Assertion helpers shared by the RTL; they expect clk and arst_n in scope.
`ifndef MAX_INDEPENDENT_SET_MIN_COST_MACROS_SVH
`define MAX_INDEPENDENT_SET_MIN_COST_MACROS_SVH

// Same-cycle implication.
`define MISMC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MISMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mismc_pkg.sv */
`timescale 1ns / 1ps
package mismc_pkg;

	localparam int ID_W       = 10;
	localparam int PRICE_W    = 16;
	localparam int SIZE_W     = 7;
	localparam int COST_W     = 22;
	localparam int BND_W      = 8;
	localparam int SLOT_MAX_W = 6;
	localparam int CNT_MAX_W  = 7;
	localparam int PAIR_MAX_W = 12;
	localparam int PCNT_MAX_W = 13;

	// Bound code: values at or above BND_ZERO are real bounds (code - BND_ZERO),
	// values below stand for an unreachable branch.
	localparam logic [BND_W-1:0] BND_ZERO = 8'd128;
	localparam logic [BND_W-1:0] BND_NONE = 8'd0;
	localparam logic [BND_W-1:0] BND_ONE  = 8'd1;

	typedef enum logic [1:0] {
		REQ_ITEM  = 2'd0,
		REQ_PAIR  = 2'd1,
		REQ_START = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		PH_EXCL = 2'd0,
		PH_INCL = 2'd1
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PR_RD,
		ST_PR_MAP,
		ST_PR_CHK,
		ST_PR_ROW,
		ST_PR_WR,
		ST_NODE,
		ST_DEC0,
		ST_INC,
		ST_FIN,
		ST_RET,
		ST_POP,
		ST_EM_RD,
		ST_EM_CMP,
		ST_EM_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic                  pair_re;
		logic [PAIR_MAX_W-1:0] pair_addr;
		logic                  map_re;
		logic [ID_W-1:0]       map_addr_a;
		logic [ID_W-1:0]       map_addr_b;
		logic                  sid_re;
		logic [SLOT_MAX_W-1:0] sid_addr_a;
		logic [SLOT_MAX_W-1:0] sid_addr_b;
		logic                  price_re;
		logic [SLOT_MAX_W-1:0] price_addr;
		logic                  clear;
	} tab_req_t;

	typedef struct packed {
		logic [ID_W-1:0]       pair_a;
		logic [ID_W-1:0]       pair_b;
		logic [CNT_MAX_W-1:0]  map_a;
		logic [CNT_MAX_W-1:0]  map_b;
		logic [ID_W-1:0]       sid_a;
		logic [ID_W-1:0]       sid_b;
		logic [PRICE_W-1:0]    price;
		logic [CNT_MAX_W-1:0]  item_count;
		logic [PCNT_MAX_W-1:0] pair_count;
	} tab_rsp_t;

	function automatic logic [BND_W-1:0] bnd_max(input logic [BND_W-1:0] a,
		input logic [BND_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* rtl/mismc_if.sv */
`timescale 1ns / 1ps
interface mismc_req_if;
	import mismc_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [ID_W-1:0]    id_a;
	logic [ID_W-1:0]    id_b;
	logic [PRICE_W-1:0] price;
	modport source (output valid, req_type, id_a, id_b, price, input ready);
	modport sink (input valid, req_type, id_a, id_b, price, output ready);
endinterface

interface mismc_res_if;
	import mismc_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] set_size;
	logic [COST_W-1:0] total_cost;
	logic [ID_W-1:0]   item_id;
	logic              last;
	modport source (output valid, set_size, total_cost, item_id, last, input ready);
	modport sink (input valid, set_size, total_cost, item_id, last, output ready);
endinterface

/* rtl/mismc_tables.sv */
`timescale 1ns / 1ps
module mismc_tables #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_PAIRS = 1024,
	parameter int ID_SPACE  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_item,
	input  logic                          wr_pair,
	input  logic [mismc_pkg::ID_W-1:0]    id_a,
	input  logic [mismc_pkg::ID_W-1:0]    id_b,
	input  logic [mismc_pkg::PRICE_W-1:0] price,
	input  mismc_pkg::tab_req_t           tq,
	output mismc_pkg::tab_rsp_t           tr,
	output logic                          init_busy
);
	import mismc_pkg::*;

	localparam int SW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int PCW = $clog2(MAX_PAIRS + 1);
	localparam int IW  = $clog2(ID_SPACE);

	logic [CW-1:0]       map_mem [ID_SPACE];
	logic [ID_W-1:0]     sid_mem [MAX_ITEMS];
	logic [PRICE_W-1:0]  price_mem [MAX_ITEMS];
	logic [2*ID_W-1:0]   pair_mem [MAX_PAIRS];

	logic [CW-1:0]       icnt_q;
	logic [PCW-1:0]      pcnt_q;
	logic [IW:0]         init_q;
	logic [2*ID_W-1:0]   pair_rd_q;
	logic [CW-1:0]       map_a_rd_q;
	logic [CW-1:0]       map_b_rd_q;
	logic [ID_W-1:0]     sid_a_rd_q;
	logic [ID_W-1:0]     sid_b_rd_q;
	logic [PRICE_W-1:0]  price_rd_q;
	logic                item_ok;
	logic                pair_ok;
	logic                a_in;
	logic                b_in;

	assign a_in      = {1'b0, id_a} < (ID_W + 1)'(ID_SPACE);
	assign b_in      = {1'b0, id_b} < (ID_W + 1)'(ID_SPACE);
	assign item_ok   = wr_item && a_in && (icnt_q < CW'(MAX_ITEMS));
	assign pair_ok   = wr_pair && a_in && b_in && (pcnt_q < PCW'(MAX_PAIRS));
	assign init_busy = (init_q != (IW + 1)'(ID_SPACE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icnt_q <= '0;
			pcnt_q <= '0;
		end else if (tq.clear) begin
			icnt_q <= '0;
			pcnt_q <= '0;
		end else begin
			if (item_ok)
				icnt_q <= icnt_q + 1'b1;
			if (pair_ok)
				pcnt_q <= pcnt_q + 1'b1;
		end
	end

	// Step through every id once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			init_q <= '0;
		else if (init_busy)
			init_q <= init_q + 1'b1;
	end

	// A map entry counts only if it points at a slot of this run holding the same id.
	always_ff @(posedge clk) begin
		if (item_ok) begin
			sid_mem[icnt_q[SW-1:0]]   <= id_a;
			price_mem[icnt_q[SW-1:0]] <= price;
		end
		if (init_busy)
			map_mem[init_q[IW-1:0]] <= '0;
		else if (item_ok)
			map_mem[id_a[IW-1:0]] <= CW'(icnt_q + 1'b1);
		if (pair_ok)
			pair_mem[pcnt_q[PW-1:0]] <= {id_a, id_b};
		if (tq.pair_re)
			pair_rd_q <= pair_mem[tq.pair_addr[PW-1:0]];
		if (tq.map_re) begin
			map_a_rd_q <= map_mem[tq.map_addr_a[IW-1:0]];
			map_b_rd_q <= map_mem[tq.map_addr_b[IW-1:0]];
		end
		if (tq.sid_re) begin
			sid_a_rd_q <= sid_mem[tq.sid_addr_a[SW-1:0]];
			sid_b_rd_q <= sid_mem[tq.sid_addr_b[SW-1:0]];
		end
		if (tq.price_re)
			price_rd_q <= price_mem[tq.price_addr[SW-1:0]];
	end

	assign tr.pair_a     = pair_rd_q[2*ID_W-1:ID_W];
	assign tr.pair_b     = pair_rd_q[ID_W-1:0];
	assign tr.map_a      = CNT_MAX_W'(map_a_rd_q);
	assign tr.map_b      = CNT_MAX_W'(map_b_rd_q);
	assign tr.sid_a      = sid_a_rd_q;
	assign tr.sid_b      = sid_b_rd_q;
	assign tr.price      = price_rd_q;
	assign tr.item_count = CNT_MAX_W'(icnt_q);
	assign tr.pair_count = PCNT_MAX_W'(pcnt_q);

endmodule

/* rtl/mismc_search.sv */
`timescale 1ns / 1ps
`include "max_independent_set_min_cost_macros.svh"
module mismc_search #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_PAIRS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output mismc_pkg::tab_req_t tq,
	input  mismc_pkg::tab_rsp_t tr,
	mismc_res_if.source         res
);
	import mismc_pkg::*;

	localparam int SW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int KW  = $clog2(MAX_ITEMS + 1);
	localparam int PCW = $clog2(MAX_PAIRS + 1);
	localparam int STW = MAX_ITEMS + 2 + BND_W;

	state_t state_q, state_d;

	logic [MAX_ITEMS-1:0] row_mem [MAX_ITEMS];
	logic [BND_W-1:0]     sb_mem [MAX_ITEMS + 1];
	logic [STW-1:0]       stk_mem [MAX_ITEMS + 1];

	logic [MAX_ITEMS-1:0] row_vld_q;
	logic [MAX_ITEMS:0]   sb_vld_q;
	logic [MAX_ITEMS-1:0] row_rd_q;
	logic                 rowv_rd_q;
	logic [BND_W-1:0]     sb_rd_q;
	logic                 sbv_rd_q;
	logic [STW-1:0]       stk_rd_q;

	logic [PCW-1:0]       i_q;
	logic [ID_W-1:0]      pa_q, pb_q;
	logic [KW-1:0]        ma_q, mb_q;
	logic [SW-1:0]        lo_q, hi_q;
	logic [KW-1:0]        k_q;
	logic [MAX_ITEMS-1:0] ban_q, set_q, best_set_q;
	logic [SIZE_W-1:0]    siz_q, best_size_q, em_cnt_q;
	logic [COST_W-1:0]    cost_q, best_cost_q;
	logic [BND_W-1:0]     r_q;
	logic [KW-1:0]        j_q;
	logic [ID_W-1:0]      cand_id_q, last_id_q;
	logic [SW-1:0]        cand_slot_q, last_slot_q;
	logic                 cand_ok_q, have_last_q;

	logic [KW-1:0]        count;
	logic [PCW-1:0]       pcount;
	logic [SW-1:0]        k_slot, j_slot;
	logic [MAX_ITEMS-1:0] kbit;
	logic [MAX_ITEMS-1:0] row_eff;
	logic [BND_W-1:0]     sb_eff, sb_val;
	logic [SIZE_W:0]      sum0;
	logic                 fit0, fit1, cond2, leaf, better;
	logic                 ma_ok, mb_ok, pr_ok, take;
	logic [KW-1:0]        ma_m1, mb_m1;
	logic [MAX_ITEMS-1:0] stk_ban;
	logic [1:0]           stk_ph;
	logic [BND_W-1:0]     stk_r1;
	logic [ID_W+SW-1:0]   em_key;
	logic [COST_W-1:0]    price_x;

	logic                 row_re, sb_re, stk_re;
	logic [SW-1:0]        row_raddr;
	logic [KW-1:0]        sb_raddr, stk_raddr;
	logic                 row_we, sb_we, stk_we;
	logic [MAX_ITEMS-1:0] row_wdata;
	logic [STW-1:0]       stk_wdata;

	assign count   = tr.item_count[KW-1:0];
	assign pcount  = tr.pair_count[PCW-1:0];
	assign k_slot  = k_q[SW-1:0];
	assign j_slot  = j_q[SW-1:0];
	assign kbit    = MAX_ITEMS'(1) << k_slot;
	assign row_eff = rowv_rd_q ? row_rd_q : '0;
	assign sb_eff  = sbv_rd_q ? sb_rd_q : BND_ZERO;
	assign sb_val  = sb_eff - BND_ZERO;
	assign sum0    = {1'b0, siz_q} + {1'b0, sb_val[SIZE_W-1:0]};
	assign fit0    = (sb_eff >= BND_ZERO) && (sum0 >= {1'b0, best_size_q});
	assign fit1    = (sb_eff >= BND_ZERO) && ((sum0 + 1'b1) >= {1'b0, best_size_q});
	assign cond2   = !ban_q[k_slot] && fit1;
	assign leaf    = (k_q == count);
	assign better  = (siz_q > best_size_q) ||
		((siz_q == best_size_q) && (cost_q < best_cost_q));
	assign price_x = COST_W'(tr.price);

	assign ma_m1 = ma_q - 1'b1;
	assign mb_m1 = mb_q - 1'b1;
	assign ma_ok = (ma_q != '0) && (ma_q <= count) && (tr.sid_a == pa_q);
	assign mb_ok = (mb_q != '0) && (mb_q <= count) && (tr.sid_b == pb_q);
	assign pr_ok = ma_ok && mb_ok && (ma_q != mb_q);

	assign stk_r1  = stk_rd_q[BND_W-1:0];
	assign stk_ph  = stk_rd_q[BND_W+1:BND_W];
	assign stk_ban = stk_rd_q[BND_W+2 +: MAX_ITEMS];

	assign em_key = {tr.sid_a, j_slot};
	assign take   = best_set_q[j_slot] &&
		(!have_last_q || (em_key > {last_id_q, last_slot_q})) &&
		(!cand_ok_q || (em_key < {cand_id_q, cand_slot_q}));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_PR_RD;
			ST_PR_RD:  state_d = (i_q == pcount) ? ST_NODE : ST_PR_MAP;
			ST_PR_MAP: state_d = ST_PR_CHK;
			ST_PR_CHK: state_d = ST_PR_ROW;
			ST_PR_ROW: state_d = pr_ok ? ST_PR_WR : ST_PR_RD;
			ST_PR_WR:  state_d = ST_PR_RD;
			ST_NODE:   state_d = leaf ? ST_RET : ST_DEC0;
			ST_DEC0:   state_d = fit0 ? ST_NODE : ST_INC;
			ST_INC:    state_d = cond2 ? ST_NODE : ST_FIN;
			ST_FIN:    state_d = ST_RET;
			ST_RET: begin
				if (k_q != '0)
					state_d = ST_POP;
				else
					state_d = (best_size_q == '0) ? ST_EM_OUT : ST_EM_RD;
			end
			ST_POP:    state_d = (stk_ph == PH_INCL) ? ST_FIN : ST_INC;
			ST_EM_RD:  state_d = ST_EM_CMP;
			ST_EM_CMP: state_d = (KW'(j_q + 1'b1) == count) ? ST_EM_OUT : ST_EM_RD;
			ST_EM_OUT: if (res.ready) state_d = res.last ? ST_CLEAR : ST_EM_RD;
			ST_CLEAR:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory and table requests
	always_comb begin
		tq        = '0;
		row_re    = 1'b0;
		row_raddr = k_slot;
		sb_re     = 1'b0;
		sb_raddr  = KW'(k_q + 1'b1);
		stk_re    = 1'b0;
		stk_raddr = KW'(k_q - 1'b1);
		row_we    = 1'b0;
		row_wdata = row_eff | (MAX_ITEMS'(1) << hi_q);
		sb_we     = 1'b0;
		stk_we    = 1'b0;
		stk_wdata = {ban_q, PH_EXCL, BND_NONE};
		case (state_q)
			ST_PR_RD: begin
				tq.pair_re   = 1'b1;
				tq.pair_addr = PAIR_MAX_W'(i_q);
			end
			ST_PR_MAP: begin
				tq.map_re     = 1'b1;
				tq.map_addr_a = tr.pair_a;
				tq.map_addr_b = tr.pair_b;
			end
			ST_PR_CHK: begin
				tq.sid_re     = 1'b1;
				tq.sid_addr_a = SLOT_MAX_W'(tr.map_a - 1'b1);
				tq.sid_addr_b = SLOT_MAX_W'(tr.map_b - 1'b1);
			end
			ST_PR_ROW: begin
				row_re    = 1'b1;
				row_raddr = (ma_q < mb_q) ? ma_m1[SW-1:0] : mb_m1[SW-1:0];
			end
			ST_PR_WR: row_we = 1'b1;
			ST_NODE: begin
				if (!leaf) begin
					row_re        = 1'b1;
					sb_re         = 1'b1;
					tq.price_re   = 1'b1;
					tq.price_addr = SLOT_MAX_W'(k_slot);
				end
			end
			ST_DEC0: stk_we = 1'b1;
			ST_INC: begin
				stk_we    = cond2;
				stk_wdata = {ban_q, PH_INCL, r_q};
			end
			ST_FIN: sb_we = (siz_q == '0);
			ST_RET: begin
				// Fetch the parent's frame and operands.
				if (k_q != '0) begin
					row_re        = 1'b1;
					row_raddr     = stk_raddr[SW-1:0];
					sb_re         = 1'b1;
					sb_raddr      = k_q;
					stk_re        = 1'b1;
					tq.price_re   = 1'b1;
					tq.price_addr = SLOT_MAX_W'(stk_raddr);
				end
			end
			ST_EM_RD: begin
				tq.sid_re     = 1'b1;
				tq.sid_addr_a = SLOT_MAX_W'(j_slot);
			end
			ST_CLEAR: tq.clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[lo_q] <= row_wdata;
		if (row_re)
			row_rd_q <= row_mem[row_raddr];
		if (sb_we)
			sb_mem[k_q] <= r_q;
		if (sb_re)
			sb_rd_q <= sb_mem[sb_raddr];
		if (stk_we)
			stk_mem[k_q] <= stk_wdata;
		if (stk_re)
			stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_vld_q <= '0;
			sb_vld_q  <= '0;
			rowv_rd_q <= 1'b0;
			sbv_rd_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (row_re)
				rowv_rd_q <= row_vld_q[row_raddr];
			if (sb_re)
				sbv_rd_q <= sb_vld_q[sb_raddr];
			if (row_we)
				row_vld_q[lo_q] <= 1'b1;
			if (sb_we)
				sb_vld_q[k_q] <= 1'b1;
			if (state_q == ST_PR_RD && i_q == pcount)
				sb_vld_q <= '0;
			if (state_q == ST_CLEAR)
				row_vld_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: i_q <= '0;
			ST_PR_RD: begin
				if (i_q == pcount) begin
					best_set_q  <= '0;
					best_size_q <= '0;
					best_cost_q <= '0;
					k_q         <= '0;
					ban_q       <= '0;
					set_q       <= '0;
					siz_q       <= '0;
					cost_q      <= '0;
				end
			end
			ST_PR_MAP: begin
				pa_q <= tr.pair_a;
				pb_q <= tr.pair_b;
			end
			ST_PR_CHK: begin
				ma_q <= tr.map_a[KW-1:0];
				mb_q <= tr.map_b[KW-1:0];
			end
			ST_PR_ROW: begin
				lo_q <= (ma_q < mb_q) ? ma_m1[SW-1:0] : mb_m1[SW-1:0];
				hi_q <= (ma_q < mb_q) ? mb_m1[SW-1:0] : ma_m1[SW-1:0];
				if (!pr_ok)
					i_q <= i_q + 1'b1;
			end
			ST_PR_WR: i_q <= i_q + 1'b1;
			ST_NODE: begin
				if (leaf) begin
					if (better) begin
						best_size_q <= siz_q;
						best_cost_q <= cost_q;
						best_set_q  <= set_q;
					end
					r_q <= BND_ZERO;
				end
			end
			ST_DEC0: begin
				if (fit0)
					k_q <= k_q + 1'b1;
				else
					r_q <= BND_NONE;
			end
			ST_INC: begin
				if (cond2) begin
					ban_q  <= ban_q | row_eff;
					siz_q  <= siz_q + 1'b1;
					cost_q <= cost_q + price_x;
					set_q  <= set_q | kbit;
					k_q    <= k_q + 1'b1;
				end else begin
					r_q <= bnd_max(r_q, BND_ONE);
				end
			end
			ST_RET: begin
				if (k_q != '0) begin
					k_q <= k_q - 1'b1;
				end else begin
					j_q         <= '0;
					cand_ok_q   <= 1'b0;
					have_last_q <= 1'b0;
					em_cnt_q    <= '0;
				end
			end
			ST_POP: begin
				ban_q <= stk_ban;
				// Undo the include step; the exclude branch result stays in r_q as r1.
				if (stk_ph == PH_INCL) begin
					r_q    <= bnd_max(stk_r1, r_q + 1'b1);
					siz_q  <= siz_q - 1'b1;
					cost_q <= cost_q - price_x;
					set_q  <= set_q & ~kbit;
				end
			end
			ST_EM_CMP: begin
				if (take) begin
					cand_id_q   <= tr.sid_a;
					cand_slot_q <= j_slot;
					cand_ok_q   <= 1'b1;
				end
				j_q <= j_q + 1'b1;
			end
			ST_EM_OUT: begin
				if (res.ready) begin
					last_id_q   <= cand_id_q;
					last_slot_q <= cand_slot_q;
					have_last_q <= 1'b1;
					em_cnt_q    <= em_cnt_q + 1'b1;
					j_q         <= '0;
					cand_ok_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign res.valid      = (state_q == ST_EM_OUT);
	assign res.set_size   = best_size_q;
	assign res.total_cost = best_cost_q;
	assign res.item_id    = (best_size_q == '0) ? '0 : cand_id_q;
	assign res.last       = (best_size_q == '0) || (SIZE_W'(em_cnt_q + 1'b1) == best_size_q);

	`MISMC_ASSERT_IMPL(a_level_range, state_q == ST_NODE, k_q <= count, "search level past item count")
	`MISMC_ASSERT_IMPL(a_size_track, state_q == ST_NODE || state_q == ST_FIN, $countones(set_q) == siz_q, "set size out of step with set")
	`MISMC_ASSERT_NEXT(a_last_clears, res.valid && res.ready && res.last, state_q == ST_CLEAR, "tables not cleared after final result")

endmodule

/* rtl/max_independent_set_min_cost.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload                                   Handshake
// req      in   req_type, id_a, id_b, price               valid/ready
// res      out  set_size, total_cost, item_id, last       valid/ready
//
// Item and pair requests are taken one per cycle while idle.
// A start request resolves each pair through PR_RD, PR_MAP, PR_CHK, PR_ROW and, for a valid pair,
// PR_WR, then runs the depth-first search; the stack, bound and conflict memories
// set its pace. Each result is selected by a scan over the loaded items, then waits on ready.
// Ready stays low from a start until the tables are cleared after the final result is taken.
// Reset starts a pass that zeroes the id map, one id per cycle over all ID_SPACE ids; ready stays low meanwhile.
module max_independent_set_min_cost #(
	parameter int MAX_ITEMS = 64,
	parameter int MAX_PAIRS = 1024,
	parameter int ID_SPACE  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mismc_req_if.sink   req,
	mismc_res_if.source res
);
	import mismc_pkg::*;

	tab_req_t tq;
	tab_rsp_t tr;
	logic     busy;
	logic     init_busy;
	logic     accept;
	logic     wr_item;
	logic     wr_pair;
	logic     start;

	assign req.ready = !busy && !init_busy;
	assign accept    = req.valid && req.ready;
	assign wr_item   = accept && (req.req_type == REQ_ITEM);
	assign wr_pair   = accept && (req.req_type == REQ_PAIR);
	assign start     = accept && (req.req_type == REQ_START);

	mismc_tables #(
		.MAX_ITEMS (MAX_ITEMS),
		.MAX_PAIRS (MAX_PAIRS),
		.ID_SPACE  (ID_SPACE)
	) u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_item   (wr_item),
		.wr_pair   (wr_pair),
		.id_a      (req.id_a),
		.id_b      (req.id_b),
		.price     (req.price),
		.tq        (tq),
		.tr        (tr),
		.init_busy (init_busy)
	);

	mismc_search #(
		.MAX_ITEMS (MAX_ITEMS),
		.MAX_PAIRS (MAX_PAIRS)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.tq     (tq),
		.tr     (tr),
		.res    (res)
	);

endmodule

/* tb/sv/mis_result_checker.sv */
`timescale 1ns / 1ps
module mis_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	mismc_req_if        req,
	mismc_res_if        res,
	output int          fail_count,
	output int          pending
);
	import mismc_pkg::*;

	localparam int NITEM  = 64;
	localparam int NPAIR  = 1024;
	localparam int NID    = 1024;
	localparam int NO_WAY = -32'sh3f3f3f3f;

	typedef struct {
		logic [SIZE_W-1:0] size;
		logic [COST_W-1:0] cost;
		logic [ID_W-1:0]   id;
		logic              last;
	} pick_t;

	pick_t       picks_q[$];
	int          slot_of[NID];
	int unsigned price_of[NITEM];
	int unsigned id_of[NITEM];
	int          pair_a[NPAIR];
	int          pair_b[NPAIR];
	int          n_pairs;
	int          n_items;
	logic [63:0] rows[NITEM];
	int          bound[NITEM+2];
	logic [63:0] top_set;
	int          top_size;
	int unsigned top_cost;

	// depth-first frames, one per search level (NITEM + 1)
	logic [63:0] f_ban[NITEM+1];
	logic [63:0] f_set[NITEM+1];
	int          f_size[NITEM+1];
	int unsigned f_cost[NITEM+1];
	int          f_step[NITEM+1];
	int          f_r1[NITEM+1];
	int          f_r2[NITEM+1];

	function automatic void wipe_tables();
		foreach (slot_of[i]) slot_of[i] = 0;
		foreach (rows[i]) rows[i] = '0;
		foreach (bound[i]) bound[i] = 0;
		n_pairs  = 0;
		n_items  = 0;
		top_set  = '0;
		top_size = 0;
		top_cost = 0;
	endfunction

	function automatic void offer_leaf(int k);
		if (f_size[k] > top_size) begin
			top_size = f_size[k];
			top_cost = f_cost[k];
			top_set  = f_set[k];
		end else if (f_size[k] == top_size && f_cost[k] < top_cost) begin
			top_cost = f_cost[k];
			top_set  = f_set[k];
		end
	endfunction

	function automatic void open_child(int k, logic [63:0] ban, int sz, int unsigned cost,
		logic [63:0] set);
		f_ban[k]  = ban;
		f_size[k] = sz;
		f_cost[k] = cost;
		f_set[k]  = set;
		f_step[k] = 0;
	endfunction

	// Exhaustive search, exclude before include, with suffix bound pruning.
	function automatic void best_set_search();
		int k;
		int r;
		bit done;
		k = 0;
		done = 0;
		open_child(0, '0, 0, 0, '0);
		while (!done) begin
			r = 0;
			if (f_step[k] == 0 && k >= n_items) begin
				offer_leaf(k);
				r = 0;
				f_step[k] = 3;
			end else if (f_step[k] == 0) begin
				f_r1[k] = NO_WAY;
				f_r2[k] = NO_WAY;
				f_step[k] = 1;
				if (f_size[k] + bound[k+1] >= top_size) begin
					open_child(k + 1, f_ban[k], f_size[k], f_cost[k], f_set[k]);
					k++;
				end
			end else if (f_step[k] == 1) begin
				f_step[k] = 2;
				if (!f_ban[k][k] && f_size[k] + 1 + bound[k+1] >= top_size) begin
					open_child(k + 1, f_ban[k] | rows[k], f_size[k] + 1,
						f_cost[k] + price_of[k], f_set[k] | (64'd1 << k));
					k++;
				end
			end else begin
				if (f_step[k] == 2) begin
					r = (f_r1[k] > f_r2[k] + 1) ? f_r1[k] : f_r2[k] + 1;
					if (f_size[k] == 0) bound[k] = r;
				end
				// hand the value back to the parent
				if (k == 0) begin
					done = 1;
				end else begin
					k--;
					if (f_step[k] == 1) f_r1[k] = r;
					else f_r2[k] = r;
				end
			end
		end
	endfunction

	function automatic void predict_start();
		int sa;
		int sb;
		int n;
		int j;
		int unsigned ids[NITEM];
		pick_t p;
		for (int i = 0; i < n_pairs; i++) begin
			sa = slot_of[pair_a[i]];
			sb = slot_of[pair_b[i]];
			if (sa != 0 && sb != 0 && sa != sb) begin
				if (sa < sb) rows[sa-1][sb-1] = 1'b1;
				else rows[sb-1][sa-1] = 1'b1;
			end
		end
		foreach (bound[i]) bound[i] = 0;
		best_set_search();
		n = 0;
		for (int i = 0; i < n_items; i++) begin
			if (top_set[i]) begin
				j = n;
				while (j > 0 && ids[j-1] > id_of[i]) begin
					ids[j] = ids[j-1];
					j--;
				end
				ids[j] = id_of[i];
				n++;
			end
		end
		if (n == 0) begin
			p = '{size: '0, cost: '0, id: '0, last: 1'b1};
			picks_q.push_back(p);
		end
		for (int i = 0; i < n; i++) begin
			p.size = n;
			p.cost = top_cost;
			p.id   = ids[i];
			p.last = (i + 1 == n);
			picks_q.push_back(p);
		end
		wipe_tables();
	endfunction

	task automatic report(string field, int unsigned got, int unsigned want);
		$display("%0t: result mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		pick_t w;
		if (!arst_n) begin
			wipe_tables();
			picks_q.delete();
		end else begin
			if (req.valid && req.ready) begin
				case (req.req_type)
					REQ_ITEM: begin
						if (n_items < NITEM) begin
							price_of[n_items] = req.price;
							id_of[n_items] = req.id_a;
							n_items++;
							slot_of[req.id_a] = n_items;
						end
					end
					REQ_PAIR: begin
						if (n_pairs < NPAIR) begin
							pair_a[n_pairs] = req.id_a;
							pair_b[n_pairs] = req.id_b;
							n_pairs++;
						end
					end
					REQ_START: predict_start();
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (picks_q.size() == 0) begin
					$display("%0t: result with nothing expected, id %0d", $realtime,
						res.item_id);
					fail_count++;
				end else begin
					w = picks_q.pop_front();
					if (res.set_size !== w.size) report("set_size", res.set_size, w.size);
					if (res.total_cost !== w.cost) report("total_cost", res.total_cost, w.cost);
					if (res.item_id !== w.id) report("item_id", res.item_id, w.id);
					if (res.last !== w.last) report("last", res.last, w.last);
				end
			end
		end
		pending = picks_q.size();
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import mismc_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	bit   calm;
	bit   hold_go;
	int   hold_left;

	mismc_req_if req ();
	mismc_res_if res ();

	max_independent_set_min_cost u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	mis_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL max_independent_set_min_cost");
		$finish;
	end

	// result side: random stalls, one long hold-off on demand
	initial begin
		res.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (calm) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= 17);
			end
		end
	end

	task automatic offer(logic [1:0] kind, logic [9:0] a, logic [9:0] b, logic [15:0] p);
		int gap;
		if (!calm && $urandom_range(0, 99) < 17) begin
			gap = $urandom_range(1, 3);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.req_type <= kind;
		req.id_a     <= a;
		req.id_b     <= b;
		req.price    <= p;
		do @(posedge clk); while (!req.ready);
		if (kind != REQ_SPARE) sent++;
		calm = (sent >= 130 && sent < 190);
	endtask

	task automatic random_set(bit press);
		int unsigned pool[12];
		int n_it;
		int n_pr;
		int unsigned pick;
		logic [15:0] p;
		foreach (pool[i]) pool[i] = $urandom_range(0, 1023);
		n_it = $urandom_range(0, 10);
		n_pr = $urandom_range(0, 2 * n_it + 1);
		while (n_it + n_pr > 0) begin
			if ($urandom_range(0, 19) == 0)
				offer(REQ_SPARE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
			if (n_it > 0 && (n_pr == 0 || $urandom_range(0, 1))) begin
				pick = $urandom_range(0, 9);
				case ($urandom_range(0, 3))
					0: p = $urandom_range(0, 15);
					1: p = 16'hffff - $urandom_range(0, 15);
					default: p = $urandom;
				endcase
				offer(REQ_ITEM, pool[pick], $urandom_range(0, 1023), p);
				n_it--;
			end else begin
				offer(REQ_PAIR, pool[$urandom_range(0, 11)], pool[$urandom_range(0, 11)],
					$urandom);
				n_pr--;
			end
		end
		if (press) hold_go = 1;
		offer(REQ_START, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
	endtask

	initial begin
		bit pressed;
		int waited;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_ITEM;
		req.id_a = '0;
		req.id_b = '0;
		req.price = '0;
		sent = 0;
		calm = 0;
		hold_go = 0;
		pressed = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty run
		offer(REQ_START, 10'd0, 10'd0, 16'd0);
		// id and price extremes, self pair, repeated pair, pair on absent ids
		offer(REQ_ITEM, 10'd0, 10'd0, 16'd0);
		offer(REQ_PAIR, 10'd0, 10'd1023, 16'd0);
		offer(REQ_ITEM, 10'd1023, 10'd1023, 16'hffff);
		offer(REQ_PAIR, 10'd0, 10'd0, 16'd0);
		offer(REQ_PAIR, 10'd1023, 10'd0, 16'd0);
		offer(REQ_ITEM, 10'd512, 10'd0, 16'd7);
		offer(REQ_PAIR, 10'd1023, 10'd512, 16'd0);
		offer(REQ_PAIR, 10'd5, 10'd6, 16'd0);
		offer(REQ_START, 10'd0, 10'd0, 16'd0);
		// repeated id takes a new slot; spare request code does nothing
		offer(REQ_ITEM, 10'd7, 10'd0, 16'd5);
		offer(REQ_ITEM, 10'd7, 10'd0, 16'd1);
		offer(REQ_SPARE, 10'd7, 10'd8, 16'd0);
		offer(REQ_ITEM, 10'd8, 10'd0, 16'd3);
		offer(REQ_PAIR, 10'd8, 10'd7, 16'd0);
		offer(REQ_START, 10'd0, 10'd0, 16'd0);
		// equal cost tie keeps the first set found
		offer(REQ_ITEM, 10'd10, 10'd0, 16'd4);
		offer(REQ_ITEM, 10'd11, 10'd0, 16'd4);
		offer(REQ_PAIR, 10'd11, 10'd10, 16'd0);
		offer(REQ_START, 10'd0, 10'd0, 16'd0);
		// overfill the item table, then chain conflicts on loaded ids
		for (int i = 0; i < 66; i++) offer(REQ_ITEM, 10'(100 + i), 10'd0, 16'hffff);
		for (int i = 0; i < 6; i++) offer(REQ_PAIR, 10'(100 + i), 10'(101 + i), 16'd0);
		offer(REQ_START, 10'd0, 10'd0, 16'd0);

		while (sent < 280) begin
			random_set(!pressed && sent > 200);
			if (sent > 200) pressed = 1;
		end
		req.valid <= 1'b0;

		// let the checker log the last start before watching the queue
		repeat (2) @(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS max_independent_set_min_cost");
		end else begin
			$display("FAIL max_independent_set_min_cost");
		end
		$finish;
	end

endmodule
